>>> design/pbe_pkg.sv
// ----------------------------------------------------------------------------
// pbe_pkg
// Shared widths, codes and constants of the PCI bus enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package pbe_pkg;

  // Table depth and the widths that follow from it
  localparam int MAX_DEVICES = 32;
  localparam int COUNT_W     = $clog2(MAX_DEVICES + 1);
  localparam int IDX_W       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

  // Field widths
  localparam int REQ_W    = 2;
  localparam int DATA_W   = 32;
  localparam int KEY_W    = 16;
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 64;
  localparam int BUS_W    = 8;
  localparam int SLOT_W   = 5;
  localparam int FUNC_W   = 3;
  localparam int OFS_W    = 8;
  localparam int INDEX_W  = 5;
  localparam int DCOUNT_W = 6;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 64;
  localparam int ENTRY_W  = 64;

  typedef enum logic [REQ_W-1:0] {
    REQ_START      = 2'd0,
    REQ_COMPLETION = 2'd1,
    REQ_FIND_ID    = 2'd2,
    REQ_FIND_CLASS = 2'd3
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ECAM_BASE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_OFFSET = 8'd1;

  // Config space offsets that the walk reads
  localparam logic [OFS_W-1:0] OFS_IDS   = 8'h00;
  localparam logic [OFS_W-1:0] OFS_CLASS = 8'h08;
  localparam logic [OFS_W-1:0] OFS_HTYPE = 8'h0C;

  localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
  localparam logic [31:0] CF8_ENABLE  = 32'h8000_0000;
  localparam int          HTYPE_MF_BIT = 16 + 7;  // header type bit 7 in the dword

  localparam logic [BUS_W-1:0]  BUS_LAST  = 8'hFF;
  localparam logic [SLOT_W-1:0] SLOT_LAST = 5'h1F;
  localparam logic [FUNC_W-1:0] FUNC_LAST = 3'h7;

endpackage

`default_nettype wire

>>> design/pbe_if.sv
// ----------------------------------------------------------------------------
// pbe_if
// Handshake channels of the enumerator: request, response and config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbe_req_if;
  logic                        valid;
  logic                        ready;
  logic [pbe_pkg::REQ_W-1:0]   req_type;
  logic [pbe_pkg::DATA_W-1:0]  read_data;
  logic [pbe_pkg::KEY_W-1:0]   key_a;
  logic [pbe_pkg::KEY_W-1:0]   key_b;

  modport source (output valid, req_type, read_data, key_a, key_b, input ready);
  modport sink   (input valid, req_type, read_data, key_a, key_b, output ready);
endinterface

interface pbe_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pbe_pkg::KIND_W-1:0]    kind;
  logic [pbe_pkg::ADDR_W-1:0]    address;
  logic [pbe_pkg::BUS_W-1:0]     bus;
  logic [pbe_pkg::SLOT_W-1:0]    slot;
  logic [pbe_pkg::FUNC_W-1:0]    func;
  logic [pbe_pkg::OFS_W-1:0]     config_offset;
  logic                          found;
  logic [pbe_pkg::INDEX_W-1:0]   index;
  logic [pbe_pkg::DCOUNT_W-1:0]  device_count;

  modport source (output valid, kind, address, bus, slot, func, config_offset, found,
                  index, device_count, input ready);
  modport sink   (input valid, kind, address, bus, slot, func, config_offset, found,
                  index, device_count, output ready);
endinterface

interface pbe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pbe_pkg::CFG_IDX_W-1:0]  index;
  logic [pbe_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/pci_bus_enumerator_core.sv
// ----------------------------------------------------------------------------
// pci_bus_enumerator_core
// Walks bus/slot/function space with dword config reads, records present
// functions in a device table memory and answers first-match lookups.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  req     | in  | valid/ready   | req_type, read_data, key_a, key_b
//  rsp     | out | valid/ready   | kind, address, bus, slot, func,
//          |     |               | config_offset, found, index, device_count
//  cfg     | in  | valid/ready   | index (register), data
//
//  Steps: accept, then execute; a lookup then reads the table from entry 0
//  and stops on the first hit, past the last stored entry, or if it is empty;
//  the single table read port, one entry per cycle, sets the lookup time.
//  Reset (rst, synchronous) clears control and config; the fill count bounds
//  every table read, so the table needs no clearing pass.
//  Stalls: a waiting result holds one more item in execute; cfg always ready.
//
`default_nettype none

module pci_bus_enumerator_core (
  input  wire       clk,
  input  wire       rst,
  pbe_req_if.sink   req,
  pbe_rsp_if.source rsp,
  pbe_cfg_if.sink   cfg
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOOK
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_IDS   = 2'd1,
    PH_CLASS = 2'd2,
    PH_HTYPE = 2'd3
  } phase_t;

  // Config registers and the precomputed ECAM base sum
  logic [pbe_pkg::ADDR_W-1:0] ecam_base;
  logic [pbe_pkg::ADDR_W-1:0] map_offset;
  logic [pbe_pkg::ADDR_W-1:0] base_sum;

  // Control
  state_t state;
  phase_t phase;
  logic [pbe_pkg::BUS_W-1:0]   scan_bus;
  logic [pbe_pkg::SLOT_W-1:0]  scan_slot;
  logic [pbe_pkg::FUNC_W-1:0]  scan_func;
  logic [pbe_pkg::DATA_W-1:0]  held_ids;
  logic [pbe_pkg::COUNT_W-1:0] stored_count;

  // Captured item
  pbe_pkg::req_t               req_q;
  logic [pbe_pkg::DATA_W-1:0]  data_q;
  logic [pbe_pkg::KEY_W-1:0]   key_a_q;
  logic [pbe_pkg::KEY_W-1:0]   key_b_q;

  // Lookup walk
  logic [pbe_pkg::COUNT_W-1:0] ptr;
  logic                        rd_valid;
  logic [pbe_pkg::IDX_W-1:0]   rd_idx;

  // Device table: vendor[15:0] device[31:16] subclass[39:32] class[47:40]
  // bus[55:48] slot[60:56] func[63:61]
  logic [pbe_pkg::ENTRY_W-1:0] dev_mem [pbe_pkg::MAX_DEVICES];
  logic [pbe_pkg::ENTRY_W-1:0] rd_data;
  logic                        rd_en;
  logic                        wr_en;

  // Result register
  logic                          rsp_valid;
  logic [pbe_pkg::KIND_W-1:0]    rsp_kind;
  logic [pbe_pkg::ADDR_W-1:0]    rsp_address;
  logic [pbe_pkg::BUS_W-1:0]     rsp_bus;
  logic [pbe_pkg::SLOT_W-1:0]    rsp_slot;
  logic [pbe_pkg::FUNC_W-1:0]    rsp_func;
  logic [pbe_pkg::OFS_W-1:0]     rsp_ofs;
  logic                          rsp_found;
  logic [pbe_pkg::INDEX_W-1:0]   rsp_index;
  logic [pbe_pkg::DCOUNT_W-1:0]  rsp_count;

  // Walk step decode
  logic                        step_func;
  logic                        step_slot;
  logic                        emit_rd;
  logic                        emit_done;
  logic                        hold_ids;
  logic [pbe_pkg::OFS_W-1:0]   rd_ofs;
  logic [pbe_pkg::BUS_W-1:0]   nb;
  logic [pbe_pkg::SLOT_W-1:0]  ns;
  logic [pbe_pkg::FUNC_W-1:0]  nf;
  phase_t                      ph_next;
  logic [pbe_pkg::ADDR_W-1:0]  rd_address;

  logic rsp_free;
  logic issue;
  logic hit;
  logic is_lookup;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp_free  = !rsp_valid || rsp.ready;
  assign is_lookup = (req_q == pbe_pkg::REQ_FIND_ID) || (req_q == pbe_pkg::REQ_FIND_CLASS);

  assign rsp.valid         = rsp_valid;
  assign rsp.kind          = rsp_kind;
  assign rsp.address       = rsp_address;
  assign rsp.bus           = rsp_bus;
  assign rsp.slot          = rsp_slot;
  assign rsp.func          = rsp_func;
  assign rsp.config_offset = rsp_ofs;
  assign rsp.found         = rsp_found;
  assign rsp.index         = rsp_index;
  assign rsp.device_count  = rsp_count;

  // Config writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ecam_base  <= '0;
      map_offset <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        pbe_pkg::REG_ECAM_BASE:  ecam_base  <= cfg.data;
        pbe_pkg::REG_MAP_OFFSET: map_offset <= cfg.data;
        default: ;
      endcase
    end
  end

  // Change config only while idle (unchecked) so the sum's registered lag stays unseen
  always_ff @(posedge clk) begin
    base_sum <= ecam_base + map_offset;
  end

  // Next location of the walk and which read comes next
  always_comb begin
    step_func = 1'b0;
    step_slot = 1'b0;
    emit_rd   = 1'b0;
    emit_done = 1'b0;
    hold_ids  = 1'b0;
    wr_en     = 1'b0;
    rd_ofs    = pbe_pkg::OFS_IDS;
    nb        = scan_bus;
    ns        = scan_slot;
    nf        = scan_func;
    ph_next   = phase;
    case (req_q)
      pbe_pkg::REQ_START: begin
        nb      = '0;
        ns      = '0;
        nf      = '0;
        ph_next = PH_IDS;
        emit_rd = 1'b1;
      end
      pbe_pkg::REQ_COMPLETION: begin
        case (phase)
          PH_IDS: begin
            if (data_q[15:0] == pbe_pkg::VENDOR_NONE) begin
              // absent: function 0 skips the whole slot
              step_slot = (scan_func == '0);
              step_func = (scan_func != '0);
            end else begin
              hold_ids = 1'b1;
              ph_next  = PH_CLASS;
              rd_ofs   = pbe_pkg::OFS_CLASS;
              emit_rd  = 1'b1;
            end
          end
          PH_CLASS: begin
            wr_en = (stored_count < pbe_pkg::COUNT_W'(pbe_pkg::MAX_DEVICES));
            if (scan_func == '0) begin
              ph_next = PH_HTYPE;
              rd_ofs  = pbe_pkg::OFS_HTYPE;
              emit_rd = 1'b1;
            end else begin
              step_func = 1'b1;
            end
          end
          PH_HTYPE: begin
            step_func = data_q[pbe_pkg::HTYPE_MF_BIT];
            step_slot = !data_q[pbe_pkg::HTYPE_MF_BIT];
          end
          default: ;  // completion while idle: ignored
        endcase
      end
      default: ;  // lookups leave the walk alone
    endcase

    if (step_func && (scan_func != pbe_pkg::FUNC_LAST)) begin
      nf      = scan_func + 1'b1;
      ph_next = PH_IDS;
      emit_rd = 1'b1;
    end else if (step_func || step_slot) begin
      nf      = '0;
      ph_next = PH_IDS;
      emit_rd = 1'b1;
      if (scan_slot != pbe_pkg::SLOT_LAST) begin
        ns = scan_slot + 1'b1;
      end else begin
        ns = '0;
        if (scan_bus != pbe_pkg::BUS_LAST) begin
          nb = scan_bus + 1'b1;
        end else begin
          // end of the walk
          nb        = '0;
          ph_next   = PH_IDLE;
          emit_rd   = 1'b0;
          emit_done = 1'b1;
        end
      end
    end

    if (ecam_base != '0) begin
      rd_address = base_sum + {36'd0, nb, ns, nf, 4'd0, rd_ofs[7:2], 2'b00};
    end else begin
      rd_address = {32'd0, pbe_pkg::CF8_ENABLE | {8'd0, nb, ns, nf, rd_ofs[7:2], 2'b00}};
    end
  end

  // Lookup compare on the entry read last cycle
  always_comb begin
    if (req_q == pbe_pkg::REQ_FIND_CLASS) begin
      hit = (rd_data[47:40] == key_a_q[7:0]) && (rd_data[39:32] == key_b_q[7:0]);
    end else begin
      hit = (rd_data[15:0] == key_a_q) && (rd_data[31:16] == key_b_q);
    end
  end

  assign issue = (state == S_LOOK) && (ptr < stored_count);
  assign rd_en = issue;

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_EXEC && rsp_free && wr_en) begin
      dev_mem[stored_count[pbe_pkg::IDX_W-1:0]] <=
        {scan_func, scan_slot, scan_bus, data_q[31:16], held_ids};
    end
    if (rd_en) begin
      rd_data <= dev_mem[ptr[pbe_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_IDLE;
      scan_bus     <= '0;
      scan_slot    <= '0;
      scan_func    <= '0;
      held_ids     <= '0;
      stored_count <= '0;
      rsp_valid    <= 1'b0;
      rd_valid     <= 1'b0;
      ptr          <= '0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_q   <= pbe_pkg::req_t'(req.req_type);
            data_q  <= req.read_data;
            key_a_q <= req.key_a;
            key_b_q <= req.key_b;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (rsp_free) begin
            if (is_lookup) begin
              ptr      <= '0;
              rd_valid <= 1'b0;
              state    <= S_LOOK;
            end else begin
              phase     <= ph_next;
              scan_bus  <= nb;
              scan_slot <= ns;
              scan_func <= nf;
              if (req_q == pbe_pkg::REQ_START) begin
                stored_count <= '0;
                held_ids     <= '0;
              end else if (wr_en) begin
                stored_count <= stored_count + 1'b1;
              end
              if (hold_ids) begin
                held_ids <= data_q;
              end
              if (emit_rd || emit_done) begin
                rsp_valid   <= 1'b1;
                rsp_kind    <= emit_rd ? pbe_pkg::KIND_READ : pbe_pkg::KIND_DONE;
                rsp_address <= emit_rd ? rd_address : '0;
                rsp_bus     <= emit_rd ? nb : '0;
                rsp_slot    <= emit_rd ? ns : '0;
                rsp_func    <= emit_rd ? nf : '0;
                rsp_ofs     <= emit_rd ? rd_ofs : '0;
                rsp_found   <= 1'b0;
                rsp_index   <= '0;
                // count including this item's table write
                rsp_count   <= (req_q == pbe_pkg::REQ_START) ? '0 :
                               pbe_pkg::DCOUNT_W'(stored_count +
                                                  pbe_pkg::COUNT_W'(wr_en));
              end
              state <= S_IDLE;
            end
          end
        end
        S_LOOK: begin
          // the result register is known free here
          if (issue) begin
            ptr <= ptr + 1'b1;
          end
          rd_valid <= issue;
          rd_idx   <= ptr[pbe_pkg::IDX_W-1:0];
          if ((rd_valid && hit) || (!rd_valid && !issue)) begin
            rsp_valid   <= 1'b1;
            rsp_kind    <= pbe_pkg::KIND_LOOKUP;
            rsp_address <= '0;
            rsp_ofs     <= '0;
            rsp_count   <= pbe_pkg::DCOUNT_W'(stored_count);
            if (rd_valid) begin
              rsp_bus   <= rd_data[55:48];
              rsp_slot  <= rd_data[60:56];
              rsp_func  <= rd_data[63:61];
              rsp_found <= 1'b1;
              rsp_index <= pbe_pkg::INDEX_W'(rd_idx);
            end else begin
              rsp_bus   <= '0;
              rsp_slot  <= '0;
              rsp_func  <= '0;
              rsp_found <= 1'b0;
              rsp_index <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> dv/pbe_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbe_tb_pkg
// Walk predictor and result scoreboard for the PCI bus enumerator bench.
// ----------------------------------------------------------------------------

package pbe_tb_pkg;
  import pbe_pkg::*;

  typedef enum logic [1:0] {
    WALK_IDLE  = 2'd0,
    WALK_IDS   = 2'd1,
    WALK_CLASS = 2'd2,
    WALK_HTYPE = 2'd3
  } walk_t;

  typedef struct packed {
    kind_t                 kind;
    logic [ADDR_W-1:0]     address;
    logic [BUS_W-1:0]      bus;
    logic [SLOT_W-1:0]     slot;
    logic [FUNC_W-1:0]     func;
    logic [OFS_W-1:0]      config_offset;
    logic                  found;
    logic [INDEX_W-1:0]    index;
    logic [DCOUNT_W-1:0]   device_count;
  } rsp_item_t;

  typedef struct packed {
    logic [15:0]       vendor;
    logic [15:0]       device;
    logic [7:0]        cls;
    logic [7:0]        subcls;
    logic [BUS_W-1:0]  bus;
    logic [SLOT_W-1:0] slot;
    logic [FUNC_W-1:0] func;
  } dev_entry_t;

  class enum_scoreboard;
    logic [CFG_DAT_W-1:0] ecam_base;
    logic [CFG_DAT_W-1:0] map_offset;
    walk_t                walk;
    logic [BUS_W-1:0]     cur_bus;
    logic [SLOT_W-1:0]    cur_slot;
    logic [FUNC_W-1:0]    cur_func;
    logic [31:0]          held_ids;
    logic [15:0]          held_class;
    int                   n_entries;
    dev_entry_t           dev_tab [MAX_DEVICES];
    rsp_item_t            pending_q [$];
    int errors, n_items, n_checked, n_done, n_lookups, n_hits, n_dropped;

    function new();
      ecam_base  = '0;
      map_offset = '0;
      walk       = WALK_IDLE;
      cur_bus    = '0;
      cur_slot   = '0;
      cur_func   = '0;
      held_ids   = '0;
      held_class = '0;
      n_entries  = 0;
      errors = 0; n_items = 0; n_checked = 0; n_done = 0;
      n_lookups = 0; n_hits = 0; n_dropped = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      if (idx == REG_ECAM_BASE) ecam_base = val;
      else if (idx == REG_MAP_OFFSET) map_offset = val;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function rsp_item_t blank();
      rsp_item_t r;
      r = '0;
      r.kind = KIND_READ;
      r.device_count = n_entries[DCOUNT_W-1:0];
      return r;
    endfunction

    function rsp_item_t read_req(logic [OFS_W-1:0] ofs);
      rsp_item_t r;
      r = blank();
      if (ecam_base != 0)
        r.address = ecam_base + map_offset + (64'(cur_bus) << 20) + (64'(cur_slot) << 15)
                    + (64'(cur_func) << 12) + 64'(ofs);
      else
        r.address = 64'(CF8_ENABLE | (32'(cur_bus) << 16) | (32'(cur_slot) << 11)
                        | (32'(cur_func) << 8) | 32'(ofs & 8'hFC));
      r.bus = cur_bus;
      r.slot = cur_slot;
      r.func = cur_func;
      r.config_offset = ofs;
      return r;
    endfunction

    // function 0 of the next slot, or scan done after the last slot of bus 255
    function rsp_item_t step_slot();
      rsp_item_t r;
      cur_func = '0;
      if (cur_slot == SLOT_LAST) begin
        cur_slot = '0;
        if (cur_bus == BUS_LAST) begin
          cur_bus = '0;
          walk = WALK_IDLE;
          r = blank();
          r.kind = KIND_DONE;
          n_done++;
          return r;
        end
        cur_bus++;
      end else begin
        cur_slot++;
      end
      walk = WALK_IDS;
      return read_req(OFS_IDS);
    endfunction

    function rsp_item_t step_func();
      if (cur_func == FUNC_LAST) return step_slot();
      cur_func++;
      walk = WALK_IDS;
      return read_req(OFS_IDS);
    endfunction

    function rsp_item_t lookup(bit by_class, logic [15:0] ka, logic [15:0] kb);
      rsp_item_t r;
      bit hit;
      r = blank();
      r.kind = KIND_LOOKUP;
      n_lookups++;
      for (int i = 0; i < n_entries; i++) begin
        if (by_class)
          hit = dev_tab[i].cls == ka[7:0] && dev_tab[i].subcls == kb[7:0];
        else
          hit = dev_tab[i].vendor == ka && dev_tab[i].device == kb;
        if (hit) begin
          r.bus = dev_tab[i].bus;
          r.slot = dev_tab[i].slot;
          r.func = dev_tab[i].func;
          r.found = 1'b1;
          r.index = i[INDEX_W-1:0];
          n_hits++;
          return r;
        end
      end
      return r;
    endfunction

    // Called once per accepted request item; queues the result it causes.
    function void note_item(req_t rt, logic [31:0] data, logic [15:0] ka, logic [15:0] kb);
      rsp_item_t r;
      bit has;
      has = 1'b1;
      n_items++;
      case (rt)
        REQ_START: begin
          n_entries = 0;
          cur_bus = '0;
          cur_slot = '0;
          cur_func = '0;
          held_ids = '0;
          held_class = '0;
          walk = WALK_IDS;
          r = read_req(OFS_IDS);
        end
        REQ_COMPLETION: begin
          case (walk)
            WALK_IDS: begin
              if (data[15:0] == VENDOR_NONE) begin
                r = (cur_func == 0) ? step_slot() : step_func();
              end else begin
                held_ids = data;
                walk = WALK_CLASS;
                r = read_req(OFS_CLASS);
              end
            end
            WALK_CLASS: begin
              held_class = data[31:16];
              if (n_entries < MAX_DEVICES) begin
                dev_tab[n_entries] = '{vendor: held_ids[15:0], device: held_ids[31:16],
                                       cls: held_class[15:8], subcls: held_class[7:0],
                                       bus: cur_bus, slot: cur_slot, func: cur_func};
                n_entries++;
              end else begin
                n_dropped++;
              end
              if (cur_func == 0) begin
                walk = WALK_HTYPE;
                r = read_req(OFS_HTYPE);
              end else begin
                r = step_func();
              end
            end
            WALK_HTYPE: r = data[HTYPE_MF_BIT] ? step_func() : step_slot();
            default: has = 1'b0;  // completion with no read outstanding
          endcase
        end
        REQ_FIND_ID: r = lookup(1'b0, ka, kb);
        default: r = lookup(1'b1, ka, kb);
      endcase
      if (has) pending_q.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(rsp_item_t got);
      rsp_item_t e;
      n_checked++;
      if (pending_q.size() == 0) begin
        $error("result with none outstanding: kind %0d address %0h", got.kind, got.address);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      cmp("kind", 64'(e.kind), 64'(got.kind));
      cmp("address", e.address, got.address);
      cmp("bus", 64'(e.bus), 64'(got.bus));
      cmp("slot", 64'(e.slot), 64'(got.slot));
      cmp("func", 64'(e.func), 64'(got.func));
      cmp("config_offset", 64'(e.config_offset), 64'(got.config_offset));
      cmp("found", 64'(e.found), 64'(got.found));
      cmp("index", 64'(e.index), 64'(got.index));
      cmp("device_count", 64'(e.device_count), 64'(got.device_count));
    endfunction
  endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for pci_bus_enumerator_core: drives scan, completion and lookup items,
// predicts every response from its own walk model and checks them in order.
// ----------------------------------------------------------------------------

module tb_top;
  import pbe_pkg::*;
  import pbe_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 64;   // longer than a lookup over a full table
  localparam int LONG_HOLD     = 400;  // receiver hold-off used to back up the core

  logic clk;
  logic rst;

  pbe_req_if req_ch ();
  pbe_rsp_if rsp_ch ();
  pbe_cfg_if cfg_ch ();

  pci_bus_enumerator_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  enum_scoreboard sb;

  // idle odds in percent per cycle, changed per phase by the main process
  int send_idle_pct;
  int recv_idle_pct;
  bit long_hold_req;
  int cycles;

  // small id pools so that duplicate entries and first-match cases show up
  logic [15:0] vendor_pool [4];
  logic [15:0] device_pool [4];
  logic [15:0] class_pool  [4];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("pci_bus_enumerator_core verification failed");
    $finish;
  end

  // Response side: check every accepted result, then pick ready for the next
  // cycle. The long hold-off is counted here so it does not block the sender.
  initial begin
    rsp_item_t got;
    int hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got.kind          = kind_t'(rsp_ch.kind);
        got.address       = rsp_ch.address;
        got.bus           = rsp_ch.bus;
        got.slot          = rsp_ch.slot;
        got.func          = rsp_ch.func;
        got.config_offset = rsp_ch.config_offset;
        got.found         = rsp_ch.found;
        got.index         = rsp_ch.index;
        got.device_count  = rsp_ch.device_count;
        sb.check_result(got);
      end
      if (hold_left == 0 && long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request item, idling first at random, and hand it to the
  // predictor on the edge where it is taken. valid drops only while idling.
  task automatic send_item(req_t rt, logic [31:0] data, logic [15:0] ka, logic [15:0] kb);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= rt;
    req_ch.read_data <= data;
    req_ch.key_a     <= ka;
    req_ch.key_b     <= kb;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_item(rt, data, ka, kb);
  endtask

  // Both registers back to back; valid is held across the two writes.
  task automatic write_regs(logic [CFG_DAT_W-1:0] base, logic [CFG_DAT_W-1:0] offs);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_ECAM_BASE;
    cfg_ch.data  <= base;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.note_config(REG_ECAM_BASE, base);
    cfg_ch.index <= REG_MAP_OFFSET;
    cfg_ch.data  <= offs;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.note_config(REG_MAP_OFFSET, offs);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering, let every outstanding result drain, then give a stray
  // completion time to clear the core before anything is reconfigured.
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Build one item from where the predicted walk stands: mostly a start when idle,
  // else mostly completions that keep it going, with lookups and the odd restart.
  task automatic send_shaped(output bit counted);
    req_t        rt;
    logic [31:0] data;
    logic [15:0] ka;
    logic [15:0] kb;
    int          r;
    int          pick;
    dev_entry_t  e;
    data = $urandom;
    ka   = 16'($urandom);
    kb   = 16'($urandom);
    r    = $urandom_range(999);
    if (sb.walk == WALK_IDLE) begin
      if (r < 700) rt = REQ_START;
      else if (r < 900) rt = ($urandom_range(1) != 0) ? REQ_FIND_ID : REQ_FIND_CLASS;
      else rt = REQ_COMPLETION;
    end else if (r < 5) begin
      rt = REQ_START;
    end else if (r < 85) begin
      rt = ($urandom_range(1) != 0) ? REQ_FIND_ID : REQ_FIND_CLASS;
    end else begin
      rt = REQ_COMPLETION;
      case (sb.walk)
        WALK_IDS: begin
          if ($urandom_range(99) < 45) begin
            if ($urandom_range(1) != 0) data[15:0] = vendor_pool[$urandom_range(3)];
            if (data[15:0] == VENDOR_NONE) data[15:0] = 16'hFFFE;
            if ($urandom_range(1) != 0) data[31:16] = device_pool[$urandom_range(3)];
          end else begin
            data[15:0] = VENDOR_NONE;  // absent, upper half left random
          end
        end
        WALK_CLASS: if ($urandom_range(1) != 0) data[31:16] = class_pool[$urandom_range(3)];
        default: ;  // header type: bit 23 random picks single or multi-function
      endcase
    end
    // aim most lookups at a recorded entry; class keys keep random upper bytes
    if ((rt == REQ_FIND_ID || rt == REQ_FIND_CLASS) && sb.n_entries > 0
        && $urandom_range(99) < 60) begin
      pick = $urandom_range(sb.n_entries - 1);
      e = sb.dev_tab[pick];
      if (rt == REQ_FIND_ID) begin
        ka = e.vendor;
        kb = e.device;
      end else begin
        ka[7:0] = e.cls;
        kb[7:0] = e.subcls;
      end
    end
    counted = !(rt == REQ_COMPLETION && sb.walk == WALK_IDLE);
    send_item(rt, data, ka, kb);
  endtask

  task automatic run_random(int count);
    int n;
    bit c;
    n = 0;
    while (n < count) begin
      send_shaped(c);
      n += c;
    end
  endtask

  initial begin
    int saved_idle;
    sb = new();
    vendor_pool = '{16'h8086, 16'h10DE, 16'h0000, 16'hFFFE};
    device_pool = '{16'h1234, 16'hFFFF, 16'h0000, 16'h7A2F};
    class_pool  = '{16'h0600, 16'h0C03, 16'hFFFF, 16'h0000};
    long_hold_req = 1'b0;

    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_START;
    req_ch.read_data <= '0;
    req_ch.key_a     <= '0;
    req_ch.key_b     <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_ECAM_BASE;
    cfg_ch.data      <= '0;

    // sender idles rarely, receiver often
    send_idle_pct = 9;
    recv_idle_pct = 60;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // ---- legacy CF8 addressing, directed walk first ----
    write_regs(64'h0, 64'h0);
    send_item(REQ_COMPLETION, 32'hDEAD_BEEF, 16'h0, 16'h0);  // nothing issued: ignored
    send_item(REQ_FIND_ID, 32'h0, 16'h0000, 16'h0000);       // empty table misses
    send_item(REQ_FIND_CLASS, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_item(REQ_START, 32'h0, 16'h0, 16'h0);
    send_item(REQ_COMPLETION, 32'h1234_8086, 16'h0, 16'h0);  // 0:0.0 present
    send_item(REQ_COMPLETION, 32'h0600_0000, 16'h0, 16'h0);  // class, then header type
    send_item(REQ_COMPLETION, 32'h0080_0000, 16'h0, 16'h0);  // multi-function
    send_item(REQ_COMPLETION, 32'h0000_FFFF, 16'h0, 16'h0);  // fn 1 absent
    send_item(REQ_COMPLETION, 32'hFFFF_FFFE, 16'h0, 16'h0);  // fn 2 vendor FFFE present
    send_item(REQ_COMPLETION, 32'hFFFF_0000, 16'h0, 16'h0);  // class FF/FF, no header read
    for (int f = 3; f < 8; f++)                               // fn 3..7 absent, on to slot 1
      send_item(REQ_COMPLETION, {16'($urandom_range(16'hFFFF)), VENDOR_NONE}, 16'h0, 16'h0);
    send_item(REQ_COMPLETION, 32'h0000_0000, 16'h0, 16'h0);  // vendor/device zero present
    send_item(REQ_COMPLETION, 32'h0C03_5A5A, 16'h0, 16'h0);
    send_item(REQ_COMPLETION, 32'hFF7F_FFFF, 16'h0, 16'h0);  // single-function slot
    send_item(REQ_COMPLETION, 32'hFFFF_FFFF, 16'h0, 16'h0);  // slot 2 fn 0 absent: skip
    send_item(REQ_FIND_ID, 32'h0, 16'h8086, 16'h1234);       // lookups during the walk
    send_item(REQ_FIND_CLASS, 32'h0, 16'hAAFF, 16'h55FF);    // only low bytes of keys count
    send_item(REQ_FIND_ID, 32'h0, 16'h0000, 16'h0000);
    send_item(REQ_FIND_ID, 32'h0, 16'hFFFE, 16'hFFFF);
    send_item(REQ_START, 32'h0, 16'h0, 16'h0);               // restart mid-walk
    send_item(REQ_FIND_ID, 32'h0, 16'h8086, 16'h1234);       // table cleared: miss
    run_random(400);
    settle();

    // ---- ECAM with random base and offset ----
    write_regs({$urandom, $urandom} | 64'h1, {$urandom, $urandom});
    run_random(350);
    settle();

    // ---- sender idles often, receiver rarely; ECAM at its top, sum wraps ----
    send_idle_pct = 60;
    recv_idle_pct = 9;
    write_regs('1, '1);
    run_random(175);
    // receiver holds off while items keep coming, so the core backs up
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    long_hold_req = 1'b1;
    run_random(20);
    send_idle_pct = saved_idle;
    // sender pauses until every result is back
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    run_random(175);
    settle();

    write_regs(64'h1, 64'h0);
    run_random(200);
    settle();

    // ---- no idling, legacy then ECAM with the base at its top ----
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_regs(64'h0, '1);  // offset has no effect on CF8 words
    run_random(100);
    settle();

    write_regs('1, 64'h0);
    run_random(100);
    settle();

    $display("Covered %0d request items, %0d results checked, %0d full scans",
             sb.n_items, sb.n_checked, sb.n_done);
    $display("Lookups %0d (%0d hits), %0d functions dropped on a full table",
             sb.n_lookups, sb.n_hits, sb.n_dropped);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pci_bus_enumerator_core verification clean");
    end else begin
      $display("pci_bus_enumerator_core verification failed");
    end
    $finish;
  end

endmodule

>>> pci_bus_enumerator_core.f
design/pbe_pkg.sv
design/pbe_if.sv
design/pci_bus_enumerator_core.sv
dv/pbe_tb_pkg.sv
dv/tb_top.sv
